/* src/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is low.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that must never hold on a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  `ASSERT_CLKD(label, clk, rst_n, !(cond))

`endif

/* src/rfdc_pkg.sv */
`default_nettype none

package rfdc_pkg;

  // Fixed field widths of the request and result channels
  localparam int unsigned DATA_W = 64;
  localparam int unsigned CNT_W  = 64;
  localparam int unsigned OCC_W  = 10;

  // Request operation codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the accepted request
    logic exec;      // update pointers, counters and the slot memory
    logic load_res;  // move the finished result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic res_free;  // output register is empty or being drained this cycle
  } status_t;

endpackage

`default_nettype wire

/* src/rfdc_ifs.sv */
`default_nettype none

// Request channel: one push or pop operation
interface rfdc_req_if;
  import rfdc_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [DATA_W-1:0] payload_in;

  modport source (output valid, func, payload_in, input ready);
  modport sink   (input valid, func, payload_in, output ready);
endinterface

// Result channel: outcome, occupancy and running totals
interface rfdc_res_if;
  import rfdc_pkg::*;
  logic              valid;
  logic              ready;
  logic              done_res;
  logic [DATA_W-1:0] payload_out;
  logic [OCC_W-1:0]  occupancy;
  logic [CNT_W-1:0]  pushed_total;
  logic [CNT_W-1:0]  popped_total;
  logic [CNT_W-1:0]  dropped_total;

  modport source (output valid, done_res, payload_out, occupancy, pushed_total,
                  popped_total, dropped_total, input ready);
  modport sink   (input valid, done_res, payload_out, occupancy, pushed_total,
                  popped_total, dropped_total, output ready);
endinterface

`default_nettype wire

/* src/rfdc_ctrl.sv */
`default_nettype none

module rfdc_ctrl
  import rfdc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    req_valid_i,
  output logic         req_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        // wait here until the output register can take the result
        if (status_i.res_free) begin
          cmd_o.load_res = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* src/rfdc_dp.sv */
`default_nettype none

module rfdc_dp
  import rfdc_pkg::*;
#(
  parameter int unsigned USABLE_DEPTH  = 1023,
  parameter int unsigned PAYLOAD_WIDTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output status_t                status_o,
  input  wire logic              req_func_i,
  input  wire logic [DATA_W-1:0] req_payload_i,
  input  wire logic              res_ready_i,
  output logic                   res_valid_o,
  output logic                   res_done_o,
  output logic [DATA_W-1:0]      res_payload_o,
  output logic [OCC_W-1:0]       res_occ_o,
  output logic [CNT_W-1:0]       res_pushed_o,
  output logic [CNT_W-1:0]       res_popped_o,
  output logic [CNT_W-1:0]       res_dropped_o
);

  localparam int unsigned SLOTS = USABLE_DEPTH + 1;
  localparam int unsigned PW    = $clog2(SLOTS);
  // occupancy is worked out wide enough for the ring, then cut to the field
  localparam int unsigned CW    = (PW + 1 > OCC_W) ? PW + 1 : OCC_W;

  logic [PAYLOAD_WIDTH-1:0] slots_q [SLOTS];
  logic [PAYLOAD_WIDTH-1:0] rdata_q;
  logic [PAYLOAD_WIDTH-1:0] pay_q;
  logic                     func_q;

  logic [PW-1:0]    wr_q, rd_q, wr_nxt, rd_nxt;
  logic [CNT_W-1:0] push_cnt_q, pop_cnt_q, drop_cnt_q;
  logic             done_q, pop_hit_q;

  logic             is_push, full, empty, push_ok, pop_ok;
  logic [CW-1:0]    occ_diff;

  logic             res_valid_q, res_done_q;
  logic [DATA_W-1:0] res_payload_q;
  logic [OCC_W-1:0] res_occ_q;
  logic [CNT_W-1:0] res_pushed_q, res_popped_q, res_dropped_q;

  // Pointer advance with wrap at the slot count
  assign wr_nxt = (wr_q == PW'(USABLE_DEPTH)) ? '0 : wr_q + PW'(1);
  assign rd_nxt = (rd_q == PW'(USABLE_DEPTH)) ? '0 : rd_q + PW'(1);

  assign is_push = (func_q == FUNC_PUSH);
  assign full    = (wr_nxt == rd_q);
  assign empty   = (rd_q == wr_q);
  assign push_ok = is_push && !full;
  assign pop_ok  = !is_push && !empty;

  // Entries held: write minus read, modulo the slot count
  always_comb begin
    occ_diff = CW'(wr_q) - CW'(rd_q);
    if (wr_q < rd_q) begin
      occ_diff = occ_diff + CW'(SLOTS);
    end
  end

  assign status_o.res_free = !res_valid_q || res_ready_i;

  // Request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= req_func_i;
      pay_q  <= req_payload_i[PAYLOAD_WIDTH-1:0];
    end
  end

  // Slot memory: at most one write and one registered read per operation
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (push_ok) begin
        slots_q[wr_q] <= pay_q;
      end
      rdata_q <= slots_q[rd_q];
    end
  end

  // Pointers and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q       <= '0;
      rd_q       <= '0;
      push_cnt_q <= '0;
      pop_cnt_q  <= '0;
      drop_cnt_q <= '0;
      done_q     <= 1'b0;
      pop_hit_q  <= 1'b0;
    end else if (cmd_i.exec) begin
      done_q    <= push_ok || pop_ok;
      pop_hit_q <= pop_ok;
      if (push_ok) begin
        wr_q       <= wr_nxt;
        push_cnt_q <= push_cnt_q + CNT_W'(1);
      end
      if (is_push && full) begin
        drop_cnt_q <= drop_cnt_q + CNT_W'(1);
      end
      if (pop_ok) begin
        rd_q      <= rd_nxt;
        pop_cnt_q <= pop_cnt_q + CNT_W'(1);
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.load_res) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      res_done_q    <= done_q;
      res_payload_q <= pop_hit_q ? DATA_W'(rdata_q) : '0;
      res_occ_q     <= occ_diff[OCC_W-1:0];
      res_pushed_q  <= push_cnt_q;
      res_popped_q  <= pop_cnt_q;
      res_dropped_q <= drop_cnt_q;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign res_done_o    = res_done_q;
  assign res_payload_o = res_payload_q;
  assign res_occ_o     = res_occ_q;
  assign res_pushed_o  = res_pushed_q;
  assign res_popped_o  = res_popped_q;
  assign res_dropped_o = res_dropped_q;

endmodule

`default_nettype wire

/* src/ring_fifo_with_drop_counters_core.sv */
// Ring FIFO of USABLE_DEPTH words (USABLE_DEPTH + 1 slots, one kept spare) with
// wrapping 64-bit totals of stored pushes, returned pops and dropped pushes.
// Each request (func 0 = push payload_in, func 1 = pop) gives exactly one
// result: done_res, the popped word or zero, the occupancy after the operation
// (modulo 2^10) and the three totals. A request passes through accept, the
// pointer/counter update with the slot-memory read and any push write, and
// the load of the output register. The next request is taken while a result
// still waits in the output register; a result held longer than that stalls the
// block in its last step. Slots are not cleared at reset; only written entries
// are ever returned.
`default_nettype none

module ring_fifo_with_drop_counters_core
  import rfdc_pkg::*;
#(
  parameter int unsigned USABLE_DEPTH  = 1023,
  parameter int unsigned PAYLOAD_WIDTH = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rfdc_req_if.sink    req_i,
  rfdc_res_if.source  res_o
);

  cmd_t    cmd;
  status_t status;

  rfdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rfdc_dp #(
    .USABLE_DEPTH  (USABLE_DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .req_func_i    (req_i.func),
    .req_payload_i (req_i.payload_in),
    .res_ready_i   (res_o.ready),
    .res_valid_o   (res_o.valid),
    .res_done_o    (res_o.done_res),
    .res_payload_o (res_o.payload_out),
    .res_occ_o     (res_o.occupancy),
    .res_pushed_o  (res_o.pushed_total),
    .res_popped_o  (res_o.popped_total),
    .res_dropped_o (res_o.dropped_total)
  );

endmodule

`default_nettype wire

/* src/rfdc_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module rfdc_checker
  import rfdc_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              req_valid_i,
  input wire logic              req_ready_i,
  input wire logic              res_valid_i,
  input wire logic              res_ready_i,
  input wire logic              res_done_i,
  input wire logic [DATA_W-1:0] res_payload_i,
  input wire logic [CNT_W-1:0]  res_pushed_i,
  input wire logic [CNT_W-1:0]  res_dropped_i
);

  logic req_acc;
  logic res_stall;
  logic res_fail_data;

  // Handshake terms used by the properties below
  assign req_acc       = req_valid_i && req_ready_i;
  assign res_stall     = res_valid_i && !res_ready_i;
  assign res_fail_data = res_valid_i && !res_done_i && (res_payload_i != '0);

  // One request in flight: ready drops right after an accept
  `ASSERT_CLKD(a_one_in_flight, clk_i, rst_ni, req_acc |=> !req_ready_i)

  // A failed operation never carries data
  `ASSERT_NEVER(a_fail_zero_data, clk_i, rst_ni, res_fail_data)

  // A waiting result stays presented
  `ASSERT_CLKD(a_res_holds, clk_i, rst_ni, res_stall |=> res_valid_i)

  // Pushed and dropped totals of a stalled result do not move
  `ASSERT_CLKD(a_res_stable, clk_i, rst_ni, res_stall |=> $stable({res_pushed_i, res_dropped_i}))

endmodule

bind ring_fifo_with_drop_counters_core rfdc_checker u_rfdc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_done_i    (res_o.done_res),
  .res_payload_i (res_o.payload_out),
  .res_pushed_i  (res_o.pushed_total),
  .res_dropped_i (res_o.dropped_total)
);

`default_nettype wire
